@@ design/sjf_pkg.sv @@
// Shared types, constants and codes of the shortest-job-first scheduler.
`timescale 1ns / 1ps

package sjf_pkg;

  localparam int PENDING_DEPTH = 32;
  localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

  localparam int ARR_W  = 16;
  localparam int DUR_W  = 16;
  localparam int TIME_W = 24;
  localparam int SUM_W  = 48;
  localparam int JOBS_W = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [JOBS_W-1:0] JOBS_MAX = '1;

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef enum logic [1:0] {
    KIND_DONE,
    KIND_AVG,
    KIND_FULL,
    KIND_ORDER
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEARCH,
    ST_SERVE,
    ST_DIV,
    ST_REPORT
  } state_t;

  // running best candidate passed down the chain
  typedef struct packed {
    logic             valid;
    logic [DUR_W-1:0] dur;
    logic [ARR_W-1:0] arr;
    logic [IDX_W-1:0] idx;
  } tok_t;

  // store update commands broadcast to every cell
  typedef struct packed {
    logic             insert;
    logic [IDX_W-1:0] insert_pos;
    logic [ARR_W-1:0] arr;
    logic [DUR_W-1:0] dur;
    logic             shift;
    logic [IDX_W-1:0] remove_idx;
  } chain_ctrl_t;

endpackage

@@ design/sjf_cell.sv @@
// One pending-job cell: holds an entry and relays the best candidate so far.
`timescale 1ns / 1ps

module sjf_cell
  import sjf_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  logic [CNT_W-1:0]  count,
  input  logic [TIME_W-1:0] t,
  input  chain_ctrl_t       ctrl,
  input  logic [ARR_W-1:0]  right_arr,
  input  logic [DUR_W-1:0]  right_dur,
  input  tok_t              tok_in,
  output logic [ARR_W-1:0]  entry_arr,
  output logic [DUR_W-1:0]  entry_dur,
  output tok_t              tok_out
);

  logic eligible;
  logic take_own;

  // entry is live and has arrived by the service start time
  assign eligible = (CNT_W'(idx) < count) && (TIME_W'(entry_arr) <= t);
  // strict compare: ties stay with the lower position
  assign take_own = eligible && (!tok_in.valid || (entry_dur < tok_in.dur));

  always_ff @(posedge clk) begin
    if (ctrl.insert && (idx == ctrl.insert_pos)) begin
      entry_arr <= ctrl.arr;
      entry_dur <= ctrl.dur;
    end else if (ctrl.shift && (idx >= ctrl.remove_idx)) begin
      entry_arr <= right_arr;
      entry_dur <= right_dur;
    end
  end

  always_ff @(posedge clk) begin
    if (take_own) begin
      tok_out.valid <= 1'b1;
      tok_out.dur   <= entry_dur;
      tok_out.arr   <= entry_arr;
      tok_out.idx   <= idx;
    end else begin
      tok_out <= tok_in;
    end
  end

endmodule

@@ design/sjf_chain.sv @@
// Row of pending-job cells in submission order.
`timescale 1ns / 1ps

module sjf_chain
  import sjf_pkg::*;
(
  input  logic              clk,
  input  logic [CNT_W-1:0]  count,
  input  logic [TIME_W-1:0] t,
  input  chain_ctrl_t       ctrl,
  output logic [ARR_W-1:0]  head_arr,
  output tok_t              best
);

  logic [ARR_W-1:0] e_arr [PENDING_DEPTH];
  logic [DUR_W-1:0] e_dur [PENDING_DEPTH];
  tok_t             toks  [PENDING_DEPTH];

  for (genvar k = 0; k < PENDING_DEPTH; k++) begin : g_cell
    tok_t             tin;
    logic [ARR_W-1:0] r_arr;
    logic [DUR_W-1:0] r_dur;

    if (k == 0) begin : g_first
      assign tin = '0;
    end else begin : g_mid
      assign tin = toks[k-1];
    end

    if (k == PENDING_DEPTH - 1) begin : g_end
      assign r_arr = e_arr[k];
      assign r_dur = e_dur[k];
    end else begin : g_inner
      assign r_arr = e_arr[k+1];
      assign r_dur = e_dur[k+1];
    end

    sjf_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(k)),
      .count     (count),
      .t         (t),
      .ctrl      (ctrl),
      .right_arr (r_arr),
      .right_dur (r_dur),
      .tok_in    (tin),
      .entry_arr (e_arr[k]),
      .entry_dur (e_dur[k]),
      .tok_out   (toks[k])
    );
  end

  assign head_arr = e_arr[0];
  assign best     = toks[PENDING_DEPTH-1];

endmodule

@@ design/sjf_div.sv @@
// Restoring divider, one quotient bit per cycle, for the batch average.
`timescale 1ns / 1ps

module sjf_div
  import sjf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [JOBS_W-1:0] divisor,
  output logic              done,
  output logic [SUM_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [JOBS_W-1:0] rem;
  logic [JOBS_W-1:0] dvs;
  logic [JOBS_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem, quotient[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem      <= JOBS_W'(rem_sh - {1'b0, dvs});
        quotient <= {quotient[SUM_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[JOBS_W-1:0];
        quotient <= {quotient[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ design/shortest_job_first_scheduler.sv @@
// Top level: non-preemptive shortest-job-first scheduler for one server.
`timescale 1ns / 1ps

// Usage
//   Input words (command, arrival_time, duration) enter on in_valid/in_ready;
//   result words (kind, job_arrival, finish_time, turnaround, last) leave on
//   out_valid/out_ready. last marks the final result caused by an input word.
//   One input word is worked on at a time; in_ready is high only when idle.
// Sequence
//   Submission with nothing to serve: accepted, then decided; no result.
//   Each job served: the best-candidate token walks the full cell chain
//   (one cell per cycle) before the pick is made.
//   Reject: accepted, then answered from the decide state. Flush report:
//   follows the last job served and the 48-step restoring divider for the average.
// Reset
//   Synchronous rst empties the store (count to zero) and clears the server
//   time, batch sums and output valid. No clearing pass is needed.
// Stall
//   Results sit in an output register; a new input word is taken while the
//   final one still waits. A stalled receiver holds the engine in the state
//   that has its next result ready.

module shortest_job_first_scheduler
  import sjf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [ARR_W-1:0]  arrival_time,
  input  logic [DUR_W-1:0]  duration,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        kind,
  output logic [ARR_W-1:0]  job_arrival,
  output logic [TIME_W-1:0] finish_time,
  output logic [TIME_W-1:0] turnaround,
  output logic              last
);

  state_t state, state_next;

  // batch state
  logic [CNT_W-1:0]  count, count_next;
  logic [TIME_W-1:0] sft, sft_next;          // server free time
  logic [ARR_W-1:0]  latest, latest_next;
  logic [SUM_W-1:0]  sum, sum_next;
  logic [JOBS_W-1:0] jobs_done, jobs_done_next;

  // word being worked on
  logic              held_cmd;
  logic [ARR_W-1:0]  held_arr;
  logic [DUR_W-1:0]  held_dur;
  logic [TIME_W-1:0] t_start, t_start_next;
  logic [IDX_W-1:0]  search_cnt, search_cnt_next;
  logic [TIME_W-1:0] avg, avg_next;

  // output word staging
  logic              load_out;
  kind_t             kind_next;
  logic [ARR_W-1:0]  job_arrival_next;
  logic [TIME_W-1:0] finish_time_next;
  logic [TIME_W-1:0] turnaround_next;
  logic              last_next;
  logic              slot_free;

  chain_ctrl_t       ctrl;
  logic [ARR_W-1:0]  head_arr;
  tok_t              best;

  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  quotient;

  // serve datapath
  logic [TIME_W:0]   fin_sum;
  logic [TIME_W-1:0] fin;
  logic [TIME_W-1:0] ta;
  logic [SUM_W:0]    sum_add;
  logic [CNT_W-1:0]  count_dec;
  logic              more_serves;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  sjf_chain u_chain (
    .clk      (clk),
    .count    (count),
    .t        (t_start),
    .ctrl     (ctrl),
    .head_arr (head_arr),
    .best     (best)
  );

  sjf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (jobs_done),
    .done     (div_done),
    .quotient (quotient)
  );

  // finish time saturates at 24 bits; start time never below the arrival
  assign fin_sum   = {1'b0, t_start} + (TIME_W + 1)'(best.dur);
  assign fin       = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];
  assign ta        = fin - TIME_W'(best.arr);
  assign sum_add   = {1'b0, sum} + (SUM_W + 1)'(ta);
  assign count_dec = count - 1'b1;
  // a flush always ends with a report, a submission stops at its arrival
  assign more_serves = (held_cmd == CMD_FLUSH) ||
                       ((count_dec != '0) && (fin < TIME_W'(held_arr)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    sft_next         = sft;
    latest_next      = latest;
    sum_next         = sum;
    jobs_done_next   = jobs_done;
    t_start_next     = t_start;
    search_cnt_next  = search_cnt;
    avg_next         = avg;
    load_out         = 1'b0;
    kind_next        = KIND_DONE;
    job_arrival_next = '0;
    finish_time_next = '0;
    turnaround_next  = '0;
    last_next        = 1'b1;
    div_start        = 1'b0;
    ctrl             = '0;
    ctrl.insert_pos  = count[IDX_W-1:0];
    ctrl.arr         = held_arr;
    ctrl.dur         = held_dur;
    ctrl.remove_idx  = best.idx;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if ((held_cmd == CMD_SUBMIT) && (held_arr < latest)) begin
          // out of order: reject, nothing changes
          if (slot_free) begin
            load_out         = 1'b1;
            kind_next        = KIND_ORDER;
            job_arrival_next = held_arr;
            state_next       = ST_IDLE;
          end
        end else if ((count != '0) &&
                     ((held_cmd == CMD_FLUSH) || (sft < TIME_W'(held_arr)))) begin
          // server idles up to the oldest pending arrival if none has come
          t_start_next    = (TIME_W'(head_arr) <= sft) ? sft : TIME_W'(head_arr);
          search_cnt_next = '0;
          state_next      = ST_SEARCH;
        end else if (held_cmd == CMD_FLUSH) begin
          if (jobs_done == '0) begin
            avg_next   = '0;
            state_next = ST_REPORT;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end else if (count == CNT_W'(PENDING_DEPTH)) begin
          if (slot_free) begin
            latest_next      = held_arr;
            load_out         = 1'b1;
            kind_next        = KIND_FULL;
            job_arrival_next = held_arr;
            state_next       = ST_IDLE;
          end
        end else begin
          latest_next = held_arr;
          ctrl.insert = 1'b1;
          count_next  = count + 1'b1;
          state_next  = ST_IDLE;
        end
      end

      ST_SEARCH: begin
        search_cnt_next = search_cnt + 1'b1;
        if (search_cnt == IDX_W'(PENDING_DEPTH - 1)) begin
          state_next = ST_SERVE;
        end
      end

      ST_SERVE: begin
        if (slot_free) begin
          load_out         = 1'b1;
          kind_next        = KIND_DONE;
          job_arrival_next = best.arr;
          finish_time_next = fin;
          turnaround_next  = ta;
          last_next        = !more_serves;
          sft_next         = fin;
          sum_next         = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
          jobs_done_next   = (jobs_done == JOBS_MAX) ? jobs_done : jobs_done + 1'b1;
          ctrl.shift       = 1'b1;
          count_next       = count_dec;
          state_next       = ST_DECIDE;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          avg_next   = (|quotient[SUM_W-1:TIME_W]) ? TIME_MAX : quotient[TIME_W-1:0];
          state_next = ST_REPORT;
        end
      end

      ST_REPORT: begin
        if (slot_free) begin
          load_out         = 1'b1;
          kind_next        = KIND_AVG;
          finish_time_next = sft;
          turnaround_next  = avg;
          sft_next         = '0;
          latest_next      = '0;
          sum_next         = '0;
          jobs_done_next   = '0;
          state_next       = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      sft        <= '0;
      latest     <= '0;
      sum        <= '0;
      jobs_done  <= '0;
      search_cnt <= '0;
      out_valid  <= 1'b0;
    end else begin
      count      <= count_next;
      sft        <= sft_next;
      latest     <= latest_next;
      sum        <= sum_next;
      jobs_done  <= jobs_done_next;
      search_cnt <= search_cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_cmd <= command;
      held_arr <= arrival_time;
      held_dur <= duration;
    end
    t_start <= t_start_next;
    avg     <= avg_next;
    if (load_out) begin
      kind        <= kind_next;
      job_arrival <= job_arrival_next;
      finish_time <= finish_time_next;
      turnaround  <= turnaround_next;
      last        <= last_next;
    end
  end

  // the chain must always deliver a pick when a job is served
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SERVE) |-> best.valid)
    else $error("no eligible candidate at service");

  // serving removes exactly one pending job
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SERVE && slot_free) |=> (count == $past(count) - 1'b1))
    else $error("pending count not decremented on service");

  // the report closes the batch
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && slot_free) |=> (sft == '0 && sum == '0 && jobs_done == '0))
    else $error("batch not cleared after report");

  // an accepted word is always examined in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_DECIDE))
    else $error("accepted word not examined");

  // store never overfills
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.insert) |-> (count < CNT_W'(PENDING_DEPTH)))
    else $error("insert into full store");

endmodule
